[src/dft_pkg.sv]
package dft_pkg;

  localparam int LINE_FIELDS = 4;
  localparam int VALUE_W     = 11;
  localparam int TICK_W      = 12;
  localparam int FRAME_W     = 16;
  localparam int SLOT_W      = 5;
  localparam logic [SLOT_W-1:0] SLOT_COUNT = 5'd17;
  localparam logic [SLOT_W-1:0] DATA_SLOTS = 5'd16;
  localparam logic [3:0] CS_MASK = 4'hF;

  // register indexes on the config port
  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_ONE_HIGH   = 2'd1;
  localparam logic [1:0] REG_ZERO_HIGH  = 2'd2;
  localparam logic [1:0] REG_TELEMETRY  = 2'd3;

  localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 12'd465;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 12'd348;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 12'd174;

  typedef struct packed {
    logic               start_req;
    logic [VALUE_W-1:0] throttle_lf;
    logic [VALUE_W-1:0] throttle_rf;
    logic [VALUE_W-1:0] throttle_lr;
    logic [VALUE_W-1:0] throttle_rr;
  } dft_in_t;

  typedef struct packed {
    logic line_lf;
    logic line_rf;
    logic line_lr;
    logic line_rr;
    logic busy_res;
  } dft_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] bit_period;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_high;
    logic              telemetry_request;
  } dft_cfg_t;

  // per-tick control from the bit sequencer to the channels
  typedef struct packed {
    logic              load;
    logic              update;
    logic              shift;
    logic              drive;
    logic              busy;
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] one_lim;
    logic [TICK_W-1:0] zero_lim;
  } dft_ctrl_t;

  // value, telemetry bit, xor nibble checksum
  function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] value,
                                                     input logic tlm);
    logic [11:0] w;
    logic [3:0]  cs;
    w  = {value, tlm};
    cs = (w[3:0] ^ w[7:4] ^ w[11:8]) & CS_MASK;
    return {w, cs};
  endfunction

endpackage

[src/dshot_frame_transmitter_top.sv]
// a request taken into the request register passes its line levels on to the result register
// throughput: one request per cycle while the result is not stalled, one timer tick per request,
//   between the request register and the result register
// reset (rst, synchronous, active high): timer idle, config registers back
//   to their defaults, both pipeline registers empty
module dshot_frame_transmitter_top #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  // request channel, one timer tick per request
  input  logic              req_valid,
  output logic              req_stall,
  input  dft_pkg::dft_in_t  req_data,
  // result channel, line levels of that tick
  output logic              res_valid,
  input  logic              res_stall,
  output dft_pkg::dft_out_t res_data,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dft_pkg::*;

  // channels past the four line fields are not driven
  localparam int ACTIVE = (MOTOR_COUNT < LINE_FIELDS) ? MOTOR_COUNT : LINE_FIELDS;

  dft_cfg_t  cfg;
  dft_ctrl_t ctrl;
  dft_in_t   req_q;
  dft_out_t  res_next;
  logic      req_q_valid;
  logic      advance, fire;
  logic [VALUE_W-1:0] value [LINE_FIELDS];
  logic               line  [LINE_FIELDS];

  // result register moves when empty or when the consumer takes it
  assign advance   = !res_valid || !res_stall;
  assign fire      = req_q_valid && advance;
  // request register refills when empty or when its content moves on
  assign req_stall = req_q_valid && !advance;

  dft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      req_q <= req_data;
    end
  end

  // bit timer: tick within bit, slot index, sending flag
  dft_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .start_req (req_q.start_req),
    .cfg       (cfg),
    .ctrl      (ctrl)
  );

  assign value[0] = req_q.throttle_lf;
  assign value[1] = req_q.throttle_rf;
  assign value[2] = req_q.throttle_lr;
  assign value[3] = req_q.throttle_rr;

  // one frame shifter per motor channel
  for (genvar i = 0; i < LINE_FIELDS; i++) begin : g_chan
    if (i < ACTIVE) begin : g_on
      dft_chan u_chan (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .value (value[i]),
        .tlm   (cfg.telemetry_request),
        .line  (line[i])
      );
    end else begin : g_off
      assign line[i] = 1'b0;
    end
  end

  always_comb begin
    res_next.line_lf  = line[0];
    res_next.line_rf  = line[1];
    res_next.line_lr  = line[2];
    res_next.line_rr  = line[3];
    res_next.busy_res = ctrl.busy;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= res_next;
    end
  end

endmodule

[src/dft_regs.sv]
module dft_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dft_pkg::dft_cfg_t cfg
);
  import dft_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period        <= BIT_PERIOD_RST;
      cfg.one_high          <= ONE_HIGH_RST;
      cfg.zero_high         <= ZERO_HIGH_RST;
      cfg.telemetry_request <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_BIT_PERIOD: cfg.bit_period        <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH:   cfg.one_high          <= pwdata[TICK_W-1:0];
        REG_ZERO_HIGH:  cfg.zero_high         <= pwdata[TICK_W-1:0];
        REG_TELEMETRY:  cfg.telemetry_request <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BIT_PERIOD: prdata = {20'd0, cfg.bit_period};
      REG_ONE_HIGH:   prdata = {20'd0, cfg.one_high};
      REG_ZERO_HIGH:  prdata = {20'd0, cfg.zero_high};
      REG_TELEMETRY:  prdata = {31'd0, cfg.telemetry_request};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

[src/dft_seq.sv]
module dft_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               start_req,
  input  dft_pkg::dft_cfg_t  cfg,
  output dft_pkg::dft_ctrl_t ctrl
);
  import dft_pkg::*;

  logic [TICK_W-1:0] tick_in_bit, tick_next, tick_cur, tick_inc, period;
  logic [SLOT_W-1:0] bit_index, bit_index_next, bidx_cur, bidx_inc;
  logic              sending, sending_next;
  logic              start_now, active, wrap;

  always_comb begin
    period    = (cfg.bit_period == '0) ? TICK_W'(1) : cfg.bit_period;
    start_now = !sending && start_req;
    active    = sending || start_now;
    tick_cur  = start_now ? '0 : tick_in_bit;
    bidx_cur  = start_now ? '0 : bit_index;
    tick_inc  = tick_cur + TICK_W'(1);
    wrap      = (tick_inc >= period) || (tick_inc == '0);
    bidx_inc  = bidx_cur + SLOT_W'(1);

    tick_next      = tick_in_bit;
    bit_index_next = bit_index;
    sending_next   = sending;
    if (active) begin
      sending_next   = 1'b1;
      tick_next      = wrap ? '0 : tick_inc;
      bit_index_next = bidx_cur;
      if (wrap) begin
        if (bidx_inc >= SLOT_COUNT) begin
          bit_index_next = '0;
          sending_next   = 1'b0;
        end else begin
          bit_index_next = bidx_inc;
        end
      end
    end

    ctrl.load     = start_now;
    ctrl.update   = fire && active;
    ctrl.shift    = wrap;
    ctrl.drive    = active && (bidx_cur < DATA_SLOTS);
    ctrl.busy     = active;
    ctrl.tick     = tick_cur;
    ctrl.one_lim  = (cfg.one_high > period) ? period : cfg.one_high;
    ctrl.zero_lim = (cfg.zero_high > period) ? period : cfg.zero_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_in_bit <= '0;
      bit_index   <= '0;
      sending     <= 1'b0;
    end else if (fire) begin
      tick_in_bit <= tick_next;
      bit_index   <= bit_index_next;
      sending     <= sending_next;
    end
  end

endmodule

[src/dft_chan.sv]
module dft_chan (
  input  logic                        clk,
  input  logic                        rst,
  input  dft_pkg::dft_ctrl_t          ctrl,
  input  logic [dft_pkg::VALUE_W-1:0] value,
  input  logic                        tlm,
  output logic                        line
);
  import dft_pkg::*;

  logic [FRAME_W-1:0] frame_shift, frame_cur;
  logic [TICK_W-1:0]  hi;

  always_comb begin
    frame_cur = ctrl.load ? build_frame(value, tlm) : frame_shift;
    hi        = frame_cur[FRAME_W-1] ? ctrl.one_lim : ctrl.zero_lim;
    line      = ctrl.drive && (ctrl.tick < hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
    end else if (ctrl.update) begin
      frame_shift <= ctrl.shift ? {frame_cur[FRAME_W-2:0], 1'b0} : frame_cur;
    end
  end

endmodule

[src/dft_checker.sv]
module dft_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_stall,
  input logic              res_valid,
  input logic              res_stall,
  input dft_pkg::dft_out_t res_data
);
  import dft_pkg::*;

  // a held result keeps its levels
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // idle ticks drive every line low
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.busy_res |->
      !res_data.line_lf && !res_data.line_rf && !res_data.line_lr && !res_data.line_rr)
    else $error("line high while idle");

  // requests back up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled without result backpressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !res_valid && !req_stall)
    else $error("result pending after reset");

endmodule

bind dshot_frame_transmitter_top dft_checker u_dft_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

[dv/dshot_frame_transmitter_top_test.sv]
module dshot_frame_transmitter_top_test;
  import dft_pkg::*;

  localparam int MOTORS      = 4;
  localparam int QUIET_LIMIT = 2000;   // cycles with no request or result moving
  localparam int TAIL_CYCLES = 8;      // a result passes the request register, then the result register
  localparam int SHOW_MAX    = 10;

  // value classes of a channel word
  localparam logic [VALUE_W-1:0] CMD_MAX      = 11'd47;
  localparam logic [VALUE_W-1:0] THROTTLE_MIN = 11'd48;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = 11'd2047;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  dft_in_t           req_data = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  dft_out_t          res_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  dshot_frame_transmitter_top #(.MOTOR_COUNT(MOTORS)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // line model: its own copy of the timing registers and of the frame timer
  // ---------------------------------------------------------------------------
  dft_cfg_t           timing;
  logic [FRAME_W-1:0] frames [LINE_FIELDS];
  logic [TICK_W-1:0]  tick_cnt = '0;
  logic [SLOT_W-1:0]  slot = '0;
  logic               sending = 1'b0;

  dft_out_t line_levels_due [$];   // one entry per accepted request, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int bad_count     = 0;
  int ticks_sent    = 0;
  int frames_started = 0;
  int timings_used  = 0;
  int quiet_cycles  = 0;

  // 11-bit value, telemetry bit, then the xor of the three nibbles of those 12 bits
  function automatic logic [FRAME_W-1:0] dshot_word(input logic [VALUE_W-1:0] value,
                                                    input logic tlm);
    logic [11:0] w;
    logic [3:0]  crc;
    w   = {value, tlm};
    crc = 4'(w ^ (w >> 4) ^ (w >> 8));
    return {w, crc};
  endfunction

  // one timer tick: returns the line levels the request should produce
  function automatic dft_out_t next_line_levels(input dft_in_t rq);
    logic [TICK_W-1:0]  per;
    logic [TICK_W-1:0]  hi;
    logic [VALUE_W-1:0] vals [LINE_FIELDS];
    logic [3:0]         lv;
    lv = '0;
    vals[0] = rq.throttle_lf;
    vals[1] = rq.throttle_rf;
    vals[2] = rq.throttle_lr;
    vals[3] = rq.throttle_rr;
    // a zero period runs as one tick per bit
    per = (timing.bit_period == '0) ? 12'd1 : timing.bit_period;
    // start is only taken while idle, values sampled only then
    if (!sending && rq.start_req) begin
      for (int c = 0; c < LINE_FIELDS; c++)
        frames[c] = (c < MOTORS) ? dshot_word(vals[c], timing.telemetry_request) : '0;
      tick_cnt = '0;
      slot     = '0;
      sending  = 1'b1;
      frames_started++;
    end
    if (!sending) return '0;
    // data slots only; the seventeenth slot stays low but still counts as busy
    if (slot < DATA_SLOTS) begin
      for (int c = 0; c < MOTORS && c < LINE_FIELDS; c++) begin
        hi = frames[c][FRAME_W-1] ? timing.one_high : timing.zero_high;
        if (hi > per) hi = per;   // high time saturates to the whole bit
        lv[3-c] = (tick_cnt < hi);
      end
    end
    tick_cnt = tick_cnt + 12'd1;
    // a period lowered under the running tick ends the bit right here
    if (tick_cnt >= per || tick_cnt == '0) begin
      tick_cnt = '0;
      for (int c = 0; c < LINE_FIELDS; c++) frames[c] = frames[c] << 1;
      slot = slot + 5'd1;
      if (slot >= SLOT_COUNT) begin
        slot    = '0;
        sending = 1'b0;
      end
    end
    return {lv, 1'b1};
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // random idle gap, then hold the request until it is taken
  task automatic push_tick(input dft_in_t rq, input bit typed, input dft_out_t want);
    dft_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = next_line_levels(rq);
    line_levels_due.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // hold off requests until every result is back
  task automatic drain();
    req_valid <= 1'b0;
    while (line_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle then access cycle; register lands on the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BIT_PERIOD: timing.bit_period        = val[TICK_W-1:0];
      REG_ONE_HIGH:   timing.one_high          = val[TICK_W-1:0];
      REG_ZERO_HIGH:  timing.zero_high         = val[TICK_W-1:0];
      REG_TELEMETRY:  timing.telemetry_request = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // new bit timing; a frame in flight carries on under it
  task automatic set_timing(input int per, input int one, input int zero, input bit tlm);
    drain();
    cfg_write(REG_BIT_PERIOD, per);
    cfg_write(REG_ONE_HIGH, one);
    cfg_write(REG_ZERO_HIGH, zero);
    cfg_write(REG_TELEMETRY, 32'(tlm));
    timings_used++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return VALUE_W'($urandom_range(CMD_MAX));
      1: return VALUE_W'($urandom_range(VALUE_MAX, THROTTLE_MIN));
      2: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return CMD_MAX;
          2:       return THROTTLE_MIN;
          default: return VALUE_MAX;
        endcase
      end
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // mostly plain ticks; a start now and then, often landing while busy
  function automatic dft_in_t rand_tick();
    dft_in_t rq;
    rq.start_req   = ($urandom_range(7) == 0);
    rq.throttle_lf = rand_value();
    rq.throttle_rf = rand_value();
    rq.throttle_lr = rand_value();
    rq.throttle_rr = rand_value();
    return rq;
  endfunction

  task automatic run_phase(input int per, input int one, input int zero, input bit tlm,
                           input int n, input int idle_pct, input int hold_pct);
    set_timing(per, one, zero, tlm);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int k = 0; k < n; k++) push_tick(rand_tick(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  string    field_names [5] = '{"line_lf", "line_rf", "line_lr", "line_rr", "busy_res"};
  dft_out_t want_lv;
  string    bad_fields;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (line_levels_due.size() == 0) begin
        bad_count++;
        if (bad_count <= SHOW_MAX)
          $display("result %b with nothing expected", res_data);
      end else begin
        want_lv    = line_levels_due.pop_front();
        bad_fields = "";
        for (int k = 0; k < 5; k++)
          if (res_data[4-k] !== want_lv[4-k]) bad_fields = {bad_fields, " ", field_names[k]};
        if (bad_fields != "") begin
          bad_count++;
          if (bad_count <= SHOW_MAX)
            $display("mismatch on%s: expected %b got %b", bad_fields, want_lv, res_data);
        end
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("FAIL dshot_frame_transmitter_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    dft_in_t  rq;
    bit       typed;
    dft_out_t want;
  } row_t;

  row_t directed_rows [$];

  task automatic add_row(input bit start, input logic [VALUE_W-1:0] lf,
                         input logic [VALUE_W-1:0] rf, input logic [VALUE_W-1:0] lr,
                         input logic [VALUE_W-1:0] rr, input bit typed,
                         input dft_out_t want);
    row_t r;
    r.rq    = '{start, lf, rf, lr, rr};
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    timing = '{BIT_PERIOD_RST, ONE_HIGH_RST, ZERO_HIGH_RST, 1'b0};
    for (int c = 0; c < LINE_FIELDS; c++) frames[c] = '0;

    // row 0 runs on reset timing: idle, everything low
    add_row(1'b0, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, 1'b1, 5'b00000);
    // from row 1: zero period (one tick per bit), one-bit high time above the
    // period, zero-bit high time of zero, so the lines show the frame bits
    add_row(1'b1, '0, CMD_MAX, THROTTLE_MIN, VALUE_MAX, 1'b0, '0);
    // rest of the sixteen data slots; a start in the middle must be ignored
    for (int k = 2; k <= 16; k++)
      add_row(k == 8, 11'h555, 11'h2AA, 11'h7FF, 11'h000, 1'b0, '0);
    // trailing slot: low lines, still busy
    add_row(1'b0, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, 1'b1, 5'b00001);
    // back-to-back start, all ones with telemetry set: first bit high everywhere
    add_row(1'b1, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, 1'b1, 5'b11111);
    add_row(1'b0, '0, '0, '0, '0, 1'b0, '0);
    add_row(1'b1, '0, '0, '0, '0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (i == 1) set_timing(0, 5, 0, 1'b1);
      push_tick(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: small periods for full frames, plus the extremes;
    // a change can land mid-frame, so shortened bits get exercised too
    run_phase(4, 3, 1, 1'b0, 280, 0, 0);
    run_phase(5, 4, 2, 1'b1, 280, 75, 0);
    run_phase(2, 4095, 1, 1'b0, 280, 0, 75);
    run_phase(3, 2, 0, 1'b1, 200, 21, 21);
    run_phase(4095, 4095, 2048, 1'b1, 40, 0, 0);
    run_phase(6, 0, 6, 1'b0, 80, 21, 21);

    drain();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d ticks checked over %0d bit timings, %0d frames started",
             ticks_sent, timings_used, frames_started);
    $display("%0d mismatches", bad_count);
    if (bad_count == 0) begin
      $display("PASS dshot_frame_transmitter_top");
    end else begin
      $display("FAIL dshot_frame_transmitter_top");
    end
    $finish;
  end

endmodule

[sim.f]
src/dft_pkg.sv
src/dft_regs.sv
src/dft_seq.sv
src/dft_chan.sv
src/dshot_frame_transmitter_top.sv
src/dft_checker.sv
dv/dshot_frame_transmitter_top_test.sv
